[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the NMEA field extractor.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/nsfe_pkg.sv]
// Shared types, codes and field maps of the NMEA sentence field extractor.
// No dependencies; used by all modules under rtl.
package nsfe_pkg;

    localparam int FIELD_CAPACITY_DEF = 16;

    // Special characters
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam logic [7:0] IDLE_MARK  = 8'hFF;
    localparam logic [7:0] FIELD_NONE = 8'hFF;

    // Type codes, first received byte in bits 7..0
    localparam logic [31:0] TYPE_P_RMC = 32'h434D5250;
    localparam logic [31:0] TYPE_N_RMC = 32'h434D524E;
    localparam logic [31:0] TYPE_P_GGA = 32'h41474750;
    localparam logic [31:0] TYPE_N_GGA = 32'h4147474E;
    localparam logic [31:0] TYPE_P_VTG = 32'h47545650;
    localparam logic [31:0] TYPE_N_VTG = 32'h4754564E;
    localparam logic [31:0] TYPE_P_GSV = 32'h56534750;
    localparam logic [31:0] TYPE_L_GSV = 32'h5653474C;

    // Event codes
    localparam logic [1:0] EVT_CLEAR   = 2'd0;
    localparam logic [1:0] EVT_CHAR    = 2'd1;
    localparam logic [1:0] EVT_GPS_CNT = 2'd2;
    localparam logic [1:0] EVT_GLO_CNT = 2'd3;

    // Destination codes
    localparam logic [3:0] DST_TIME    = 4'd0;
    localparam logic [3:0] DST_STATUS  = 4'd1;
    localparam logic [3:0] DST_LAT     = 4'd2;
    localparam logic [3:0] DST_NS      = 4'd3;
    localparam logic [3:0] DST_LON     = 4'd4;
    localparam logic [3:0] DST_EW      = 4'd5;
    localparam logic [3:0] DST_COURSE  = 4'd6;
    localparam logic [3:0] DST_DATE    = 4'd7;
    localparam logic [3:0] DST_USED    = 4'd8;
    localparam logic [3:0] DST_ALT     = 4'd9;
    localparam logic [3:0] DST_INVIEW  = 4'd10;
    localparam logic [3:0] DST_COG     = 4'd11;
    localparam logic [3:0] DST_COGSTAT = 4'd12;
    localparam logic [3:0] DST_KNOTS   = 4'd13;
    localparam logic [3:0] DST_SPEED   = 4'd14;
    localparam logic [3:0] DST_NONE    = 4'd15;

    typedef enum logic [2:0] {
        KIND_RMC,
        KIND_GGA,
        KIND_VTG,
        KIND_GSV_GPS,
        KIND_GSV_GLO,
        KIND_UNKNOWN
    } kind_t;

    // One result
    typedef struct packed {
        logic [7:0] sat_count;
        logic [7:0] char_value;
        logic [5:0] char_position;
        logic [3:0] destination;
        logic [1:0] event_kind;
    } evt_t;

    function automatic kind_t kind_of(input logic [31:0] code);
        kind_t k;
        if (code == TYPE_P_RMC || code == TYPE_N_RMC) k = KIND_RMC;
        else if (code == TYPE_P_GGA || code == TYPE_N_GGA) k = KIND_GGA;
        else if (code == TYPE_P_VTG || code == TYPE_N_VTG) k = KIND_VTG;
        else if (code == TYPE_P_GSV) k = KIND_GSV_GPS;
        else if (code == TYPE_L_GSV) k = KIND_GSV_GLO;
        else k = KIND_UNKNOWN;
        return k;
    endfunction

    // Field index to destination, per sentence type
    function automatic logic [3:0] dest_of(input kind_t kind, input logic [7:0] fi);
        logic [3:0] d;
        d = DST_NONE;
        case (kind)
            KIND_RMC:
            begin
                case (fi)
                    8'd0: d = DST_TIME;
                    8'd1: d = DST_STATUS;
                    8'd2: d = DST_LAT;
                    8'd3: d = DST_NS;
                    8'd4: d = DST_LON;
                    8'd5: d = DST_EW;
                    8'd7: d = DST_COURSE;
                    8'd8: d = DST_DATE;
                    default: d = DST_NONE;
                endcase
            end
            KIND_GGA:
            begin
                case (fi)
                    8'd6: d = DST_USED;
                    8'd8: d = DST_ALT;
                    default: d = DST_NONE;
                endcase
            end
            KIND_VTG:
            begin
                case (fi)
                    8'd0: d = DST_COG;
                    8'd1: d = DST_COGSTAT;
                    8'd4: d = DST_KNOTS;
                    8'd6: d = DST_SPEED;
                    default: d = DST_NONE;
                endcase
            end
            KIND_GSV_GPS, KIND_GSV_GLO:
            begin
                d = (fi == 8'd2) ? DST_INVIEW : DST_NONE;
            end
            default: d = DST_NONE;
        endcase
        return d;
    endfunction

endpackage

[rtl/nsfe_parser.sv]
// Sentence parser: holds the sentence state and turns one byte into at most one event.
// Depends on nsfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nsfe_parser #(
    parameter int FIELD_CAPACITY = nsfe_pkg::FIELD_CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,   // byte consumed this cycle
    input  logic [7:0]         in_byte,
    output logic               evt_valid,
    output nsfe_pkg::evt_t     evt
);

    localparam int CHAR_W = $clog2(FIELD_CAPACITY + 1);
    localparam logic [CHAR_W-1:0] CAP = CHAR_W'(FIELD_CAPACITY);

    logic [7:0]        byte_cnt_reg, byte_cnt_next;
    logic [31:0]       type_acc_reg, type_acc_next;
    logic [7:0]        field_idx_reg, field_idx_next;
    logic [CHAR_W-1:0] char_idx_reg, char_idx_next;
    logic [7:0]        inview_reg, inview_next;

    logic [7:0]        cnt_inc;
    logic [7:0]        field_inc;
    nsfe_pkg::kind_t   kind;
    logic [3:0]        dest_cur;
    logic [3:0]        dest_new;
    logic [11:0]       inview_mac;

    assign cnt_inc    = byte_cnt_reg + 8'd1;
    assign field_inc  = field_idx_reg + 8'd1;
    assign kind       = nsfe_pkg::kind_of(type_acc_reg);
    assign dest_cur   = nsfe_pkg::dest_of(kind, field_idx_reg);
    assign dest_new   = nsfe_pkg::dest_of(kind, field_inc);
    // value * 10 + digit
    assign inview_mac = {1'b0, inview_reg, 3'b000} + {3'b000, inview_reg, 1'b0}
                        + {8'd0, in_byte[3:0]};

    // Next state and event
    always_comb
    begin
        byte_cnt_next  = byte_cnt_reg;
        type_acc_next  = type_acc_reg;
        field_idx_next = field_idx_reg;
        char_idx_next  = char_idx_reg;
        inview_next    = inview_reg;
        evt_valid      = 1'b0;
        evt            = '0;

        if (in_valid)
        begin
            if (in_byte == nsfe_pkg::CHAR_DOLLAR)
            begin
                byte_cnt_next  = 8'd0;
                type_acc_next  = '0;
                field_idx_next = nsfe_pkg::FIELD_NONE;
                char_idx_next  = '0;
            end
            else if (byte_cnt_reg != nsfe_pkg::IDLE_MARK)
            begin
                byte_cnt_next = cnt_inc;
                if (cnt_inc == nsfe_pkg::IDLE_MARK || cnt_inc <= 8'd1)
                begin
                    // length limit hit, or talker byte
                end
                else if (cnt_inc < 8'd6)
                begin
                    case (cnt_inc)
                        8'd2: type_acc_next[7:0]   = in_byte;
                        8'd3: type_acc_next[15:8]  = in_byte;
                        8'd4: type_acc_next[23:16] = in_byte;
                        8'd5: type_acc_next[31:24] = in_byte;
                        default: type_acc_next = type_acc_reg;
                    endcase
                end
                else if (kind == nsfe_pkg::KIND_UNKNOWN)
                begin
                    byte_cnt_next = nsfe_pkg::IDLE_MARK;
                end
                else if (in_byte == nsfe_pkg::CHAR_COMMA)
                begin
                    field_idx_next = field_inc;
                    char_idx_next  = '0;
                    if (dest_new != nsfe_pkg::DST_NONE)
                    begin
                        if (dest_new == nsfe_pkg::DST_INVIEW)
                        begin
                            inview_next = 8'd0;
                        end
                        evt_valid       = 1'b1;
                        evt.event_kind  = nsfe_pkg::EVT_CLEAR;
                        evt.destination = dest_new;
                    end
                end
                else if (in_byte == nsfe_pkg::CHAR_STAR)
                begin
                    byte_cnt_next = nsfe_pkg::IDLE_MARK;
                    if (kind == nsfe_pkg::KIND_GSV_GPS || kind == nsfe_pkg::KIND_GSV_GLO)
                    begin
                        evt_valid       = 1'b1;
                        evt.event_kind  = (kind == nsfe_pkg::KIND_GSV_GPS) ?
                                          nsfe_pkg::EVT_GPS_CNT : nsfe_pkg::EVT_GLO_CNT;
                        evt.destination = nsfe_pkg::DST_INVIEW;
                        evt.sat_count   = inview_reg;
                    end
                end
                else if (dest_cur != nsfe_pkg::DST_NONE && char_idx_reg < CAP)
                begin
                    evt_valid         = 1'b1;
                    evt.event_kind    = nsfe_pkg::EVT_CHAR;
                    evt.destination   = dest_cur;
                    evt.char_position = 6'(char_idx_reg);
                    evt.char_value    = in_byte;
                    char_idx_next     = char_idx_reg + CHAR_W'(1);
                    if (dest_cur == nsfe_pkg::DST_INVIEW &&
                        in_byte inside {[nsfe_pkg::CHAR_ZERO:nsfe_pkg::CHAR_NINE]})
                    begin
                        inview_next = (inview_mac > 12'd255) ? 8'd255 : inview_mac[7:0];
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg  <= nsfe_pkg::IDLE_MARK;
            type_acc_reg  <= '0;
            field_idx_reg <= nsfe_pkg::FIELD_NONE;
            char_idx_reg  <= '0;
            inview_reg    <= '0;
        end
        else
        begin
            byte_cnt_reg  <= byte_cnt_next;
            type_acc_reg  <= type_acc_next;
            field_idx_reg <= field_idx_next;
            char_idx_reg  <= char_idx_next;
            inview_reg    <= inview_next;
        end
    end

    `ASSERT_ALWAYS(a_char_idx_cap, clk, rst_n, char_idx_reg <= CAP)
    `ASSERT_IMPLIES(a_idle_silent, clk, rst_n, in_valid && byte_cnt_reg == nsfe_pkg::IDLE_MARK && in_byte != nsfe_pkg::CHAR_DOLLAR, !evt_valid)
    `ASSERT_IMPLIES(a_count_on_star, clk, rst_n, evt_valid && (evt.event_kind == nsfe_pkg::EVT_GPS_CNT || evt.event_kind == nsfe_pkg::EVT_GLO_CNT), in_byte == nsfe_pkg::CHAR_STAR)

endmodule

[rtl/nsfe_out_buf.sv]
// Two-entry result buffer between the parser and the master stream port.
// Depends on nsfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nsfe_out_buf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nsfe_pkg::evt_t push_data,
    output logic           space,      // room for one more result
    output logic           out_valid,
    input  logic           out_ready,
    output nsfe_pkg::evt_t out_data
);

    nsfe_pkg::evt_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign space     = (cnt_reg != 2'd2);
    assign out_data  = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, cnt_reg != 2'd2)
    `ASSERT_NEXT(a_cnt_grow, clk, rst_n, push && !pop, cnt_reg == 2'($past(cnt_reg) + 2'd1))

endmodule

[rtl/nmea_sentence_field_extractor.sv]
// NMEA sentence field extractor: input byte register, parser, result buffer.
// An accepted byte is held in the input byte register; the parser turns it into
// at most one event combinationally, which is written into the result buffer.
// Throughput: one byte per cycle while the result buffer has room.
// s_tready drops only when the byte register is full and both buffer entries wait.
// Reset (rst_n low, asynchronous): parser idle, buffer empty, in-view count 0.
// Depends on nsfe_pkg, nsfe_parser and nsfe_out_buf.
module nmea_sentence_field_extractor #(
    parameter int FIELD_CAPACITY = nsfe_pkg::FIELD_CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [3:0] destination, [9:4] char_position,
                                   // [17:10] char_value, [25:18] sat_count, rest 0
    output logic [1:0]  m_tuser    // [1:0] event_kind
);

    logic           in_valid_reg;
    logic [7:0]     in_byte_reg;
    logic           consume;
    logic           buf_space;
    logic           evt_valid;
    nsfe_pkg::evt_t evt;
    nsfe_pkg::evt_t out_evt;

    assign consume  = in_valid_reg && buf_space;
    assign s_tready = !in_valid_reg || buf_space;

    // Input byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    nsfe_parser #(
        .FIELD_CAPACITY (FIELD_CAPACITY)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (consume),
        .in_byte   (in_byte_reg),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    nsfe_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (consume && evt_valid),
        .push_data (evt),
        .space     (buf_space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_evt)
    );

    // Output packing
    assign m_tuser = out_evt.event_kind;
    assign m_tdata = {6'd0, out_evt.sat_count, out_evt.char_value,
                      out_evt.char_position, out_evt.destination};

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the NMEA sentence field extractor: a directed byte table,
// then random sentences; events are checked against typed rows or a parser model.
// Depends on nsfe_pkg and the nmea_sentence_field_extractor RTL.
module testbench;

    import nsfe_pkg::*;

    localparam int FIELD_CAP   = FIELD_CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        evt_t       want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;      // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;              // [3:0] destination, [9:4] char_position,
                                       // [17:10] char_value, [25:18] sat_count
    logic [1:0]  m_tuser;              // [1:0] event_kind

    // Parser model state
    logic [7:0]  sent_len = IDLE_MARK;
    logic [31:0] type_code = '0;
    logic [7:0]  field_no = FIELD_NONE;
    logic [6:0]  char_no = '0;
    logic [7:0]  inview_cnt = '0;

    evt_t expected_events [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int live_bytes = 0;
    int directed_bytes = 0;
    int clears_seen = 0;
    int chars_seen = 0;
    int counts_seen = 0;

    // Directed bytes; typed expectations only where obvious
    stim_row_t dir_tab [28] = '{
        '{8'h00, 1'b0, '0},                 // idle, ignored
        '{8'hFF, 1'b0, '0},                 // idle, ignored
        '{CHAR_DOLLAR, 1'b0, '0},
        '{"G", 1'b0, '0},
        '{"P", 1'b0, '0},
        '{"G", 1'b0, '0},
        '{"S", 1'b0, '0},
        '{"V", 1'b0, '0},
        '{CHAR_COMMA, 1'b0, '0},
        '{CHAR_COMMA, 1'b0, '0},
        '{CHAR_COMMA, 1'b1, '{event_kind: EVT_CLEAR, destination: DST_INVIEW, default: '0}},
        '{"9", 1'b1, '{event_kind: EVT_CHAR, destination: DST_INVIEW,
                       char_value: "9", default: '0}},
        '{8'hFF, 1'b1, '{event_kind: EVT_CHAR, destination: DST_INVIEW,
                         char_position: 6'd1, char_value: 8'hFF, default: '0}},
        '{CHAR_STAR, 1'b1, '{event_kind: EVT_GPS_CNT, destination: DST_INVIEW,
                             sat_count: 8'd9, default: '0}},
        // GLONASS sentence with no in-view field reports the held count
        '{CHAR_DOLLAR, 1'b0, '0},
        '{"G", 1'b0, '0},
        '{"L", 1'b0, '0},
        '{"G", 1'b0, '0},
        '{"S", 1'b0, '0},
        '{"V", 1'b0, '0},
        '{CHAR_STAR, 1'b0, '0},
        // commas inside the type code, then an unknown type
        '{CHAR_DOLLAR, 1'b0, '0},
        '{"G", 1'b0, '0},
        '{CHAR_COMMA, 1'b0, '0},
        '{CHAR_COMMA, 1'b0, '0},
        '{CHAR_COMMA, 1'b0, '0},
        '{CHAR_COMMA, 1'b0, '0},
        '{"A", 1'b0, '0}
    };

    nmea_sentence_field_extractor #(
        .FIELD_CAPACITY (FIELD_CAP)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // Sentence type from the four stored type bytes
    function automatic kind_t sentence_kind(input logic [31:0] code);
        kind_t k;
        case (code)
            TYPE_P_RMC, TYPE_N_RMC: k = KIND_RMC;
            TYPE_P_GGA, TYPE_N_GGA: k = KIND_GGA;
            TYPE_P_VTG, TYPE_N_VTG: k = KIND_VTG;
            TYPE_P_GSV:             k = KIND_GSV_GPS;
            TYPE_L_GSV:             k = KIND_GSV_GLO;
            default:                k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Named destination of a field, DST_NONE when unmapped
    function automatic logic [3:0] field_dest(input kind_t k, input logic [7:0] idx);
        logic [3:0] d;
        d = DST_NONE;
        if (k == KIND_RMC)
        begin
            case (idx)
                8'd0: d = DST_TIME;
                8'd1: d = DST_STATUS;
                8'd2: d = DST_LAT;
                8'd3: d = DST_NS;
                8'd4: d = DST_LON;
                8'd5: d = DST_EW;
                8'd7: d = DST_COURSE;
                8'd8: d = DST_DATE;
                default: d = DST_NONE;
            endcase
        end
        else if (k == KIND_GGA)
        begin
            if (idx == 8'd6)
                d = DST_USED;
            else if (idx == 8'd8)
                d = DST_ALT;
        end
        else if (k == KIND_VTG)
        begin
            case (idx)
                8'd0: d = DST_COG;
                8'd1: d = DST_COGSTAT;
                8'd4: d = DST_KNOTS;
                8'd6: d = DST_SPEED;
                default: d = DST_NONE;
            endcase
        end
        else if ((k == KIND_GSV_GPS || k == KIND_GSV_GLO) && idx == 8'd2)
        begin
            d = DST_INVIEW;
        end
        return d;
    endfunction

    // Advance the parser model by one byte; hit is set when an event results
    function automatic void parse_byte(input logic [7:0] b, output bit hit, output evt_t ev);
        kind_t      k;
        logic [3:0] d;
        int         sh;
        int         v;
        hit = 1'b0;
        ev = '0;
        if (b == CHAR_DOLLAR)
        begin
            sent_len = 8'd0;
            type_code = '0;
            field_no = FIELD_NONE;
            char_no = '0;
            return;
        end
        if (sent_len == IDLE_MARK)
            return;
        sent_len = sent_len + 8'd1;
        // talker byte or overlong sentence: this byte is dropped; when overlong, the parser goes idle
        if (sent_len == IDLE_MARK || sent_len <= 8'd1)
            return;
        if (sent_len < 8'd6)
        begin
            sh = 8 * (int'(sent_len) - 2);
            type_code[sh +: 8] = b;
            return;
        end
        k = sentence_kind(type_code);
        if (k == KIND_UNKNOWN)
        begin
            sent_len = IDLE_MARK;
            return;
        end
        if (b == CHAR_COMMA)
        begin
            field_no = field_no + 8'd1;
            char_no = '0;
            d = field_dest(k, field_no);
            if (d == DST_NONE)
                return;
            if (d == DST_INVIEW)
                inview_cnt = '0;
            ev.event_kind = EVT_CLEAR;
            ev.destination = d;
            hit = 1'b1;
            return;
        end
        if (b == CHAR_STAR)
        begin
            sent_len = IDLE_MARK;
            if (k == KIND_GSV_GPS || k == KIND_GSV_GLO)
            begin
                ev.event_kind = (k == KIND_GSV_GPS) ? EVT_GPS_CNT : EVT_GLO_CNT;
                ev.destination = DST_INVIEW;
                ev.sat_count = inview_cnt;
                hit = 1'b1;
            end
            return;
        end
        d = field_dest(k, field_no);
        if (d == DST_NONE || char_no >= FIELD_CAP)
            return;
        ev.event_kind = EVT_CHAR;
        ev.destination = d;
        ev.char_position = char_no[5:0];
        ev.char_value = b;
        hit = 1'b1;
        char_no = char_no + 7'd1;
        // decimal in-view count, saturating
        if (d == DST_INVIEW && b >= CHAR_ZERO && b <= CHAR_NINE)
        begin
            v = int'(inview_cnt) * 10 + int'(b - CHAR_ZERO);
            inview_cnt = (v > 255) ? 8'd255 : 8'(v);
        end
    endfunction

    // Offer one byte, wait for its transfer, then record what it should cause
    task automatic send_byte(input logic [7:0] b, input bit typed, input evt_t want);
        bit   hit;
        evt_t ev;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (b == CHAR_DOLLAR || sent_len != IDLE_MARK)
            live_bytes++;
        parse_byte(b, hit, ev);
        if (typed)
            expected_events.push_back(want);
        else if (hit)
            expected_events.push_back(ev);
    endtask

    // Random field content; in-view fields are mostly digits
    function automatic logic [7:0] field_char(input bit count_field);
        int r;
        r = $urandom_range(99);
        if (count_field && r < 90)
            return 8'(CHAR_ZERO + $urandom_range(9));
        if (r < 2)
            return CHAR_DOLLAR;
        if (r < 4)
            return CHAR_STAR;
        if (r < 55)
            return 8'(CHAR_ZERO + $urandom_range(9));
        if (r < 75)
            return 8'("A" + $urandom_range(25));
        if (r < 85)
            return ".";
        return 8'($urandom_range(255));
    endfunction

    // One random sentence, possibly preceded by line noise
    task automatic send_sentence(input bit overlong);
        logic [7:0]  seq [$];
        logic [31:0] code;
        kind_t       k;
        int          n_fields;
        int          len;
        int          roll;
        string       hexdig;
        hexdig = "0123456789ABCDEF";
        if ($urandom_range(99) < 8)
            repeat ($urandom_range(1, 5)) seq.push_back(8'($urandom_range(255)));
        seq.push_back(CHAR_DOLLAR);
        seq.push_back(($urandom_range(99) < 90) ? 8'("G") : 8'($urandom_range(255)));
        case ($urandom_range(9))
            0: code = TYPE_P_RMC;
            1: code = TYPE_N_RMC;
            2: code = TYPE_P_GGA;
            3: code = TYPE_N_GGA;
            4: code = TYPE_P_VTG;
            5: code = TYPE_N_VTG;
            6: code = TYPE_P_GSV;
            7: code = TYPE_L_GSV;
            8: code = TYPE_P_GSV ^ (32'h1 << $urandom_range(31));   // near miss
            default: code = $urandom;
        endcase
        if (overlong)
            code = TYPE_P_RMC;
        for (int i = 0; i < 4; i++)
            seq.push_back(code[8*i +: 8]);
        k = sentence_kind(code);
        if (overlong)
        begin
            // no end mark: the parser must give up at the length limit
            while (seq.size() < 262)
            begin
                if ($urandom_range(7) == 0)
                    seq.push_back(CHAR_COMMA);
                else
                    seq.push_back(8'(CHAR_ZERO + $urandom_range(9)));
            end
        end
        else
        begin
            n_fields = $urandom_range(1, 11);
            for (int f = 0; f < n_fields; f++)
            begin
                seq.push_back(CHAR_COMMA);
                roll = $urandom_range(99);
                if (roll < 75)
                    len = $urandom_range(0, 6);
                else if (roll < 90)
                    len = $urandom_range(7, 12);
                else
                    len = $urandom_range(FIELD_CAP - 2, FIELD_CAP + 4);
                for (int c = 0; c < len; c++)
                    seq.push_back(field_char((k == KIND_GSV_GPS || k == KIND_GSV_GLO)
                                             && f == 2));
            end
            if ($urandom_range(99) < 88)
            begin
                seq.push_back(CHAR_STAR);
                seq.push_back(hexdig[$urandom_range(15)]);
                seq.push_back(hexdig[$urandom_range(15)]);
                seq.push_back(8'h0D);
                seq.push_back(8'h0A);
            end
        end
        foreach (seq[i])
            send_byte(seq[i], 1'b0, '0);
    endtask

    // Receiver readiness, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Event checker
    always @(posedge clk)
    begin
        evt_t got;
        evt_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.event_kind = m_tuser;
            got.destination = m_tdata[3:0];
            got.char_position = m_tdata[9:4];
            got.char_value = m_tdata[17:10];
            got.sat_count = m_tdata[25:18];
            case (got.event_kind)
                EVT_CLEAR: clears_seen++;
                EVT_CHAR:  chars_seen++;
                default:   counts_seen++;
            endcase
            if (expected_events.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected event: kind %0d dest %0d pos %0d char %02h cnt %0d",
                         $time, got.event_kind, got.destination, got.char_position,
                         got.char_value, got.sat_count);
            end
            else
            begin
                want = expected_events.pop_front();
                if (got !== want || m_tdata[31:26] !== 6'd0)
                begin
                    mismatch_count++;
                    $display("%0t: expected kind %0d dest %0d pos %0d char %02h cnt %0d",
                             $time, want.event_kind, want.destination, want.char_position,
                             want.char_value, want.sat_count);
                    $display("%0t: actual   kind %0d dest %0d pos %0d char %02h cnt %0d pad %02h",
                             $time, got.event_kind, got.destination, got.char_position,
                             got.char_value, got.sat_count, m_tdata[31:26]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d events outstanding",
                     cycle_count, expected_events.size());
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        tx_idle_pct = 15;
        rx_idle_pct = 54;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_byte(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].want);
        directed_bytes = live_bytes;

        while (live_bytes < 60)
            send_sentence(1'b0);

        tx_idle_pct = 54;
        rx_idle_pct = 15;
        while (live_bytes < 110)
            send_sentence(1'b0);

        // full rate, with a long receiver stall during the overlong sentence
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 1'b1;
        send_sentence(1'b1);
        while (live_bytes < 380)
            send_sentence(1'b0);
        s_tvalid <= 1'b0;

        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Parsed %0d bytes (%0d directed) in %0d cycles under three idling mixes",
                 live_bytes, directed_bytes, cycle_count);
        $display("Checked %0d clears, %0d characters, %0d in-view counts; overlong sentence sent",
                 clears_seen, chars_seen, counts_seen);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/nsfe_pkg.sv
rtl/nsfe_parser.sv
rtl/nsfe_out_buf.sv
rtl/nmea_sentence_field_extractor.sv
sim/testbench.sv
